### rtl/rvx_pkg.sv
// ----------------------------------------------------------------------------
// rvx_pkg
// Shared types and constants of the RV32IM executor core.
// ----------------------------------------------------------------------------
package rvx_pkg;

   localparam logic [31:0] MEM_BASE = 32'h8000_0000;
   localparam logic [31:0] RESET_PC = 32'h8000_0000;
   localparam logic [31:0] W_ECALL  = 32'h0000_0073;
   localparam logic [31:0] W_EBREAK = 32'h0010_0073;
   localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

   // major opcodes
   localparam logic [6:0] OPC_OPIMM  = 7'h13;
   localparam logic [6:0] OPC_OP     = 7'h33;
   localparam logic [6:0] OPC_LUI    = 7'h37;
   localparam logic [6:0] OPC_AUIPC  = 7'h17;
   localparam logic [6:0] OPC_JAL    = 7'h6F;
   localparam logic [6:0] OPC_JALR   = 7'h67;
   localparam logic [6:0] OPC_BRANCH = 7'h63;
   localparam logic [6:0] OPC_LOAD   = 7'h03;
   localparam logic [6:0] OPC_STORE  = 7'h23;

   // funct7
   localparam logic [6:0] F7_BASE   = 7'h00;
   localparam logic [6:0] F7_ALT    = 7'h20;
   localparam logic [6:0] F7_MULDIV = 7'h01;

   // funct3, integer ops
   localparam logic [2:0] F3_ADD  = 3'd0;
   localparam logic [2:0] F3_SLL  = 3'd1;
   localparam logic [2:0] F3_SLT  = 3'd2;
   localparam logic [2:0] F3_SLTU = 3'd3;
   localparam logic [2:0] F3_XOR  = 3'd4;
   localparam logic [2:0] F3_SR   = 3'd5;
   localparam logic [2:0] F3_OR   = 3'd6;
   localparam logic [2:0] F3_AND  = 3'd7;

   // funct3, branches
   localparam logic [2:0] F3_BEQ  = 3'd0;
   localparam logic [2:0] F3_BNE  = 3'd1;
   localparam logic [2:0] F3_BLT  = 3'd4;
   localparam logic [2:0] F3_BGE  = 3'd5;
   localparam logic [2:0] F3_BLTU = 3'd6;
   localparam logic [2:0] F3_BGEU = 3'd7;

   // funct3, loads / stores
   localparam logic [2:0] F3_LB  = 3'd0;
   localparam logic [2:0] F3_LH  = 3'd1;
   localparam logic [2:0] F3_LW  = 3'd2;
   localparam logic [2:0] F3_LBU = 3'd4;
   localparam logic [2:0] F3_LHU = 3'd5;

   // funct3, M extension
   localparam logic [2:0] F3_MUL    = 3'd0;
   localparam logic [2:0] F3_MULH   = 3'd1;
   localparam logic [2:0] F3_MULHSU = 3'd2;
   localparam logic [2:0] F3_MULHU  = 3'd3;

   // result status codes
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_ECALL   = 3'd1;
   localparam logic [2:0] ST_EBREAK  = 3'd2;
   localparam logic [2:0] ST_NULL    = 3'd3;
   localparam logic [2:0] ST_UNKNOWN = 3'd4;
   localparam logic [2:0] ST_RANGE   = 3'd5;
   localparam logic [2:0] ST_HALTED  = 3'd6;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_LDW,
      S_FETCH,
      S_DECODE,
      S_RS1,
      S_RS2,
      S_EXEC,
      S_DMEM,
      S_MDW,
      S_WB,
      S_FINISH
   } core_state_type;

   typedef struct packed {
      logic        wr;
      logic [31:0] wval;
      logic [31:0] npc;
      logic [2:0]  st;
      logic        mem_ld;
      logic        mem_st;
      logic        md;
      logic [31:0] maddr;
      logic [2:0]  mn;
   } alu_res_type;

endpackage

### rtl/rvx_alu.sv
// ----------------------------------------------------------------------------
// rvx_alu
// Decode and combinational execute: integer ops, jumps, branches, addresses.
// ----------------------------------------------------------------------------
module rvx_alu import rvx_pkg::*; (
   input  logic [31:0] ins,
   input  logic [31:0] pc,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output alu_res_type res
);

   logic [6:0]  opc;
   logic [2:0]  f3;
   logic [6:0]  f7;
   logic [31:0] imm_i, imm_s, imm_b, imm_j, imm_u;
   logic [4:0]  sh_i, sh_r;
   logic        take;

   assign opc   = ins[6:0];
   assign f3    = ins[14:12];
   assign f7    = ins[31:25];
   assign imm_i = {{20{ins[31]}}, ins[31:20]};
   assign imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
   assign imm_b = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
   assign imm_j = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
   assign imm_u = {ins[31:12], 12'd0};
   assign sh_i  = imm_i[4:0];
   assign sh_r  = b[4:0];

   always_comb begin
      case (f3)
         F3_BEQ:  take = (a == b);
         F3_BNE:  take = (a != b);
         F3_BLT:  take = ($signed(a) < $signed(b));
         F3_BGE:  take = ($signed(a) >= $signed(b));
         F3_BLTU: take = (a < b);
         F3_BGEU: take = (a >= b);
         default: take = 1'b0;
      endcase
   end

   always_comb begin
      res        = '0;
      res.npc    = pc + 32'd4;
      res.st     = ST_OK;
      case (opc)
         OPC_OPIMM: begin
            res.wr = 1'b1;
            case (f3)
               F3_ADD:  res.wval = a + imm_i;
               F3_SLL:  res.wval = a << sh_i;
               F3_SLT:  res.wval = {31'd0, $signed(a) < $signed(imm_i)};
               F3_SLTU: res.wval = {31'd0, a < imm_i};
               F3_XOR:  res.wval = a ^ imm_i;
               F3_SR: begin
                  if (f7 == F7_BASE) res.wval = a >> sh_i;
                  else if (f7 == F7_ALT) res.wval = $signed(a) >>> sh_i;
                  else res.wr = 1'b0;
               end
               F3_OR:   res.wval = a | imm_i;
               default: res.wval = a & imm_i;
            endcase
         end
         OPC_OP: begin
            res.wr = 1'b1;
            if (f7 == F7_BASE) begin
               case (f3)
                  F3_ADD:  res.wval = a + b;
                  F3_SLL:  res.wval = a << sh_r;
                  F3_SLT:  res.wval = {31'd0, $signed(a) < $signed(b)};
                  F3_SLTU: res.wval = {31'd0, a < b};
                  F3_XOR:  res.wval = a ^ b;
                  F3_SR:   res.wval = a >> sh_r;
                  F3_OR:   res.wval = a | b;
                  default: res.wval = a & b;
               endcase
            end else if (f7 == F7_ALT && f3 == F3_ADD) begin
               res.wval = a - b;
            end else if (f7 == F7_ALT && f3 == F3_SR) begin
               res.wval = $signed(a) >>> sh_r;
            end else if (f7 == F7_MULDIV) begin
               res.md = 1'b1;
            end else begin
               res.wr = 1'b0;
            end
         end
         OPC_LUI: begin
            res.wr   = 1'b1;
            res.wval = imm_u;
         end
         OPC_AUIPC: begin
            res.wr   = 1'b1;
            res.wval = pc + imm_u;
         end
         OPC_JAL: begin
            res.wr   = 1'b1;
            res.wval = pc + 32'd4;
            res.npc  = pc + imm_j;
         end
         OPC_JALR: begin
            res.wr   = 1'b1;
            res.wval = pc + 32'd4;
            res.npc  = (a + imm_i) & ~32'd1;
         end
         OPC_BRANCH: begin
            if (take) res.npc = pc + imm_b;
         end
         OPC_LOAD: begin
            res.maddr = a + imm_i;
            if (f3 inside {F3_LB, F3_LH, F3_LW, F3_LBU, F3_LHU}) begin
               res.wr     = 1'b1;
               res.mem_ld = 1'b1;
               res.mn     = (f3[1:0] == 2'd0) ? 3'd1 : ((f3[1:0] == 2'd1) ? 3'd2 : 3'd4);
            end
         end
         OPC_STORE: begin
            res.maddr = a + imm_s;
            if (f3 inside {F3_LB, F3_LH, F3_LW}) begin
               res.mem_st = 1'b1;
               res.mn     = (f3 == F3_LB) ? 3'd1 : ((f3 == F3_LH) ? 3'd2 : 3'd4);
            end
         end
         default: begin
            res.st  = ST_UNKNOWN;
            res.npc = 32'd4;
         end
      endcase
   end

endmodule

### rtl/rvx_md.sv
// ----------------------------------------------------------------------------
// rvx_md
// M-extension unit: multiplier and radix-2 restoring divider.
// ----------------------------------------------------------------------------
module rvx_md import rvx_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [2:0]  f3,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic        done,
   output logic [31:0] result
);

   logic        mul_pend_ff, mul_hi_ff;
   logic [32:0] mop_a_ff, mop_b_ff;
   logic signed [65:0] prod;

   logic [5:0]  div_cnt_ff;
   logic        div_fin_ff;
   logic [31:0] quo_ff, rem_ff, mb_ff, akeep_ff;
   logic        neg_q_ff, neg_r_ff, bzero_ff, rem_sel_ff;
   logic [32:0] rem_sh, diff;

   logic        done_ff;
   logic [31:0] result_ff;

   logic        sgn, na, nb;

   assign sgn    = ~f3[0];
   assign na     = sgn & a[31];
   assign nb     = sgn & b[31];
   assign prod   = $signed(mop_a_ff) * $signed(mop_b_ff);
   assign rem_sh = {rem_ff, quo_ff[31]};
   assign diff   = rem_sh - {1'b0, mb_ff};
   assign done   = done_ff;
   assign result = result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_pend_ff <= 1'b0;
         div_cnt_ff  <= '0;
         div_fin_ff  <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         done_ff    <= 1'b0;
         div_fin_ff <= 1'b0;
         mul_pend_ff <= 1'b0;
         if (start && !f3[2]) begin
            mul_pend_ff <= 1'b1;
            mul_hi_ff   <= (f3 != F3_MUL);
            mop_a_ff    <= {(f3 == F3_MULH || f3 == F3_MULHSU) & a[31], a};
            mop_b_ff    <= {(f3 == F3_MULH) & b[31], b};
         end
         if (mul_pend_ff) begin
            result_ff <= mul_hi_ff ? prod[63:32] : prod[31:0];
            done_ff   <= 1'b1;
         end
         if (start && f3[2]) begin
            quo_ff     <= na ? (32'd0 - a) : a;
            mb_ff      <= nb ? (32'd0 - b) : b;
            rem_ff     <= '0;
            akeep_ff   <= a;
            neg_q_ff   <= na ^ nb;
            neg_r_ff   <= na;
            bzero_ff   <= (b == '0);
            rem_sel_ff <= f3[1];
            div_cnt_ff <= 6'd32;
         end
         if (div_cnt_ff != '0) begin
            if (!diff[32]) begin
               rem_ff <= diff[31:0];
               quo_ff <= {quo_ff[30:0], 1'b1};
            end else begin
               rem_ff <= rem_sh[31:0];
               quo_ff <= {quo_ff[30:0], 1'b0};
            end
            div_cnt_ff <= div_cnt_ff - 6'd1;
            if (div_cnt_ff == 6'd1) div_fin_ff <= 1'b1;
         end
         if (div_fin_ff) begin
            done_ff <= 1'b1;
            if (bzero_ff) result_ff <= rem_sel_ff ? akeep_ff : ALL_ONES;
            else if (rem_sel_ff) result_ff <= neg_r_ff ? (32'd0 - rem_ff) : rem_ff;
            else result_ff <= neg_q_ff ? (32'd0 - quo_ff) : quo_ff;
         end
      end
   end

endmodule

### rtl/rv32im_instruction_executor_core.sv
// ----------------------------------------------------------------------------
// rv32im_instruction_executor_core
// Single-hart RV32IM executor with a byte-wide unified memory at 0x80000000.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+---------------------------------------
//  req     | in  | req_tvalid/tready  | tuser: op; tdata: load_address, data
//  rsp     | out | rsp_tvalid/tready  | tuser: status; tdata: see port list
//  csr     | in  | csr_wen            | csr_wdata: start_pc (also loads pc)
//
//  Sequence: a load transaction makes 4 byte writes. A step fetches its
//  word one byte per cycle on the single memory port, reads the registers
//  through the one register file read port, then makes any data access,
//  multiply or divide, and lastly writes back and posts the result.
//  Reset: a clearing pass zeroes the memory with req_tready low; csr writes
//  are taken during it.
//  Stalls: the result sits in an output register, so the next request is
//  taken while rsp waits; a second result waits for rsp_tready.
//
module rv32im_instruction_executor_core import rvx_pkg::*; #(
   parameter int MEM_BYTES = 65536
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wen,
   input  logic [31:0]  csr_wdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [63:0]  req_tdata,   // [31:0] load_address, [63:32] load_data
   input  logic         req_tuser,   // op
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [135:0] rsp_tdata,   // exec_pc, fetched_word, dest_written,
                                     // dest_index, dest_value, next_pc, pad
   output logic [2:0]   rsp_tuser    // status
);

   localparam int AW = $clog2(MEM_BYTES);
   localparam logic [32:0] MEM_LIM = 33'(MEM_BYTES);
   localparam logic [AW:0] CLR_LAST = (AW + 1)'(MEM_BYTES - 1);

   // range check: idx + n <= MEM_BYTES, done in 33 bits
   function automatic logic in_range(input logic [31:0] addr, input logic [2:0] n);
      logic [32:0] span;
      span = {1'b0, addr - MEM_BASE} + {30'd0, n};
      return span <= MEM_LIM;
   endfunction

   function automatic logic [AW-1:0] mem_off(input logic [31:0] addr);
      logic [31:0] d;
      d = addr - MEM_BASE;
      return d[AW-1:0];
   endfunction

   core_state_type state_ff, state_in;

   // byte memory
   logic [7:0]    mem [MEM_BYTES];
   logic [7:0]    mem_q_ff;
   logic          mem_we;
   logic [AW-1:0] mem_a;
   logic [7:0]    mem_wd;
   logic [AW:0]   clr_cnt_ff;

   // register file
   logic [31:0] rf_mem [32];
   logic [31:0] rf_vld_ff;
   logic [31:0] rf_q_ff, rf_rdata;
   logic        rf_qv_ff;
   logic [4:0]  rf_ra;
   logic        rf_we;
   logic [4:0]  rd;

   // byte access sequencer
   logic [AW-1:0] acc_addr_ff;
   logic [2:0]    acc_n_ff, acc_cnt_ff;
   logic          acc_wr_ff;
   logic [31:0]   acc_data_ff;
   logic          rd_pend_ff;
   logic [1:0]    rd_lane_ff;
   logic          acc_go, acc_act, acc_done, rd_issue;

   // architectural and per-transaction state
   logic [31:0] pc_ff, ins_ff, exec_pc_ff, a_ff, b_ff;
   logic        halted_ff;
   logic        wr_ff;
   logic [31:0] wval_ff, npc_ff;
   logic [2:0]  st_ff;

   logic         rsp_tvalid_ff;
   logic [135:0] rsp_tdata_ff;
   logic [2:0]   rsp_tuser_ff;

   alu_res_type alu_res;
   logic        md_start, md_done;
   logic [31:0] md_result;
   logic        req_acc, rsp_free;
   logic [31:0] req_addr, req_data;

   rvx_alu u_alu (
      .ins (ins_ff),
      .pc  (exec_pc_ff),
      .a   (a_ff),
      .b   (b_ff),
      .res (alu_res)
   );

   rvx_md u_md (
      .clock  (clock),
      .reset  (reset),
      .start  (md_start),
      .f3     (ins_ff[14:12]),
      .a      (a_ff),
      .b      (b_ff),
      .done   (md_done),
      .result (md_result)
   );

   assign req_addr   = req_tdata[31:0];
   assign req_data   = req_tdata[63:32];
   assign req_acc    = req_tvalid & req_tready;
   assign rsp_free   = ~rsp_tvalid_ff | rsp_tready;
   assign rd         = ins_ff[11:7];
   assign rf_rdata   = rf_qv_ff ? rf_q_ff : 32'd0;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   // sequencer handshake
   assign acc_go   = (state_ff == S_LDW) || (state_ff == S_FETCH) || (state_ff == S_DMEM);
   assign acc_act  = acc_cnt_ff < acc_n_ff;
   assign acc_done = ~acc_act & ~rd_pend_ff;
   assign rd_issue = acc_go & ~acc_wr_ff & acc_act;

   // ---------------------------------------------------------------- memories
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_a] <= mem_wd;
      mem_q_ff <= mem[mem_a];
   end

   always_ff @(posedge clock) begin
      if (rf_we) rf_mem[rd] <= wval_ff;
      rf_q_ff  <= rf_mem[rf_ra];
      rf_qv_ff <= rf_vld_ff[rf_ra];
   end

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR:  if (clr_cnt_ff == CLR_LAST) state_in = S_IDLE;
         S_IDLE: begin
            if (req_acc) begin
               if (!req_tuser) state_in = in_range(req_addr, 3'd4) ? S_LDW : S_FINISH;
               else if (halted_ff || !in_range(pc_ff, 3'd4)) state_in = S_FINISH;
               else state_in = S_FETCH;
            end
         end
         S_LDW:    if (acc_done) state_in = S_FINISH;
         S_FETCH:  if (acc_done) state_in = S_DECODE;
         S_DECODE: begin
            if (ins_ff == W_ECALL || ins_ff == W_EBREAK || ins_ff == 32'd0)
               state_in = S_FINISH;
            else
               state_in = S_RS1;
         end
         S_RS1:    state_in = S_RS2;
         S_RS2:    state_in = S_EXEC;
         S_EXEC: begin
            if (alu_res.md) state_in = S_MDW;
            else if ((alu_res.mem_ld || alu_res.mem_st) && in_range(alu_res.maddr, alu_res.mn))
               state_in = S_DMEM;
            else state_in = S_WB;
         end
         S_DMEM:   if (acc_done) state_in = S_WB;
         S_MDW:    if (md_done) state_in = S_WB;
         S_WB:     state_in = S_FINISH;
         S_FINISH: if (rsp_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- outputs
   always_comb begin
      req_tready = (state_ff == S_IDLE);
      rf_ra      = (state_ff == S_RS1) ? ins_ff[24:20] : ins_ff[19:15];
      rf_we      = (state_ff == S_WB) && wr_ff && (rd != 5'd0);
      md_start   = (state_ff == S_EXEC) && alu_res.md;
      if (state_ff == S_CLEAR) begin
         mem_we = 1'b1;
         mem_a  = clr_cnt_ff[AW-1:0];
         mem_wd = 8'd0;
      end else begin
         mem_we = acc_go & acc_wr_ff & acc_act;
         mem_a  = acc_addr_ff + AW'(acc_cnt_ff);
         mem_wd = acc_data_ff[acc_cnt_ff[1:0]*8 +: 8];
      end
   end

   // ---------------------------------------------------------------- datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_cnt_ff    <= '0;
         pc_ff         <= RESET_PC;
         halted_ff     <= 1'b0;
         rf_vld_ff     <= '0;
         rsp_tvalid_ff <= 1'b0;
         rd_pend_ff    <= 1'b0;
         acc_cnt_ff    <= '0;
         acc_n_ff      <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_CLEAR) clr_cnt_ff <= clr_cnt_ff + 1'b1;

         // byte sequencer: one byte per cycle; read data passes through mem_q_ff into acc_data_ff
         rd_pend_ff <= rd_issue;
         rd_lane_ff <= acc_cnt_ff[1:0];
         if (rd_pend_ff) acc_data_ff[rd_lane_ff*8 +: 8] <= mem_q_ff;
         if (acc_go && acc_act) acc_cnt_ff <= acc_cnt_ff + 3'd1;

         case (state_ff)
            S_IDLE: begin
               if (req_acc) begin
                  ins_ff     <= '0;
                  wr_ff      <= 1'b0;
                  wval_ff    <= '0;
                  st_ff      <= ST_OK;
                  acc_cnt_ff <= '0;
                  acc_n_ff   <= 3'd4;
                  if (!req_tuser) begin
                     exec_pc_ff  <= '0;
                     acc_addr_ff <= mem_off(req_addr);
                     acc_wr_ff   <= 1'b1;
                     acc_data_ff <= req_data;
                     if (!in_range(req_addr, 3'd4)) st_ff <= ST_RANGE;
                  end else begin
                     exec_pc_ff  <= pc_ff;
                     acc_addr_ff <= mem_off(pc_ff);
                     acc_wr_ff   <= 1'b0;
                     acc_data_ff <= '0;
                     if (halted_ff) begin
                        st_ff <= ST_HALTED;
                     end else if (!in_range(pc_ff, 3'd4)) begin
                        st_ff     <= ST_RANGE;
                        halted_ff <= 1'b1;
                     end
                  end
               end
            end
            S_FETCH: if (acc_done) ins_ff <= acc_data_ff;
            S_DECODE: begin
               if (ins_ff == W_ECALL) begin
                  st_ff <= ST_ECALL;  halted_ff <= 1'b1;
               end else if (ins_ff == W_EBREAK) begin
                  st_ff <= ST_EBREAK; halted_ff <= 1'b1;
               end else if (ins_ff == 32'd0) begin
                  st_ff <= ST_NULL;   halted_ff <= 1'b1;
               end
            end
            S_RS1: a_ff <= rf_rdata;
            S_RS2: b_ff <= rf_rdata;
            S_EXEC: begin
               wr_ff   <= alu_res.wr;
               wval_ff <= alu_res.wval;
               npc_ff  <= alu_res.npc;
               st_ff   <= alu_res.st;
               if (alu_res.mem_ld || alu_res.mem_st) begin
                  if (in_range(alu_res.maddr, alu_res.mn)) begin
                     acc_addr_ff <= mem_off(alu_res.maddr);
                     acc_n_ff    <= alu_res.mn;
                     acc_cnt_ff  <= '0;
                     acc_wr_ff   <= alu_res.mem_st;
                     acc_data_ff <= alu_res.mem_st ? b_ff : 32'd0;
                  end else begin
                     // dropped store, or a load that returns zero
                     st_ff <= ST_RANGE;
                  end
               end
            end
            S_DMEM: begin
               if (acc_done && !acc_wr_ff) begin
                  case (ins_ff[14:12])
                     F3_LB:   wval_ff <= {{24{acc_data_ff[7]}}, acc_data_ff[7:0]};
                     F3_LH:   wval_ff <= {{16{acc_data_ff[15]}}, acc_data_ff[15:0]};
                     F3_LBU:  wval_ff <= {24'd0, acc_data_ff[7:0]};
                     F3_LHU:  wval_ff <= {16'd0, acc_data_ff[15:0]};
                     default: wval_ff <= acc_data_ff;
                  endcase
               end
            end
            S_MDW: if (md_done) wval_ff <= md_result;
            S_WB: begin
               pc_ff <= npc_ff;
               if (rf_we) begin
                  rf_vld_ff[rd] <= 1'b1;
               end else begin
                  wr_ff   <= 1'b0;
                  wval_ff <= '0;
               end
            end
            default: ;
         endcase

         // output register
         if (rsp_tvalid_ff && rsp_tready) rsp_tvalid_ff <= 1'b0;
         if (state_ff == S_FINISH && rsp_free) begin
            rsp_tvalid_ff <= 1'b1;
            rsp_tdata_ff  <= {2'b00, pc_ff, wval_ff, (wr_ff ? rd : 5'd0), wr_ff,
                              ins_ff, exec_pc_ff};
            rsp_tuser_ff  <= st_ff;
         end

         // start_pc write also loads the program counter
         if (csr_wen) pc_ff <= csr_wdata;
      end
   end

endmodule

### rtl/rvx_chk.sv
// ----------------------------------------------------------------------------
// rvx_chk
// Port-level checks on the executor core, bound to the top level.
// ----------------------------------------------------------------------------
module rvx_chk import rvx_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [135:0] rsp_tdata,
   input logic [2:0]   rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp transaction changed while stalled");

   a_halted_step: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_HALTED |->
         rsp_tdata[133:102] == rsp_tdata[31:0] && rsp_tdata[63:32] == 32'd0 && !rsp_tdata[64])
      else $error("halted step changed state");

   a_no_dest: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[64] |-> rsp_tdata[69:65] == 5'd0 && rsp_tdata[101:70] == 32'd0)
      else $error("destination fields set without a write");

   a_dest_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[64] |-> rsp_tdata[69:65] != 5'd0 && rsp_tuser != ST_UNKNOWN)
      else $error("write reported to x0 or on unknown opcode");

   a_clear_pass: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("request taken before the memory clear");

endmodule

bind rv32im_instruction_executor_core rvx_chk u_rvx_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

### sim/tb_rv32im_instruction_executor_core.sv
// ----------------------------------------------------------------------------
// tb_rv32im_instruction_executor_core
// Self-checking bench for the RV32IM executor core. Instructions are placed
// one at a time at the predicted pc by load transactions and then stepped.
// A scoreboard class mirrors the hart state and checks every result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_rv32im_instruction_executor_core;
   import rvx_pkg::*;

   localparam int MEM_BYTES  = 65536;
   localparam int RAND_ITEMS = 1550;
   localparam int QUIET_FROM = 1400;     // no idling past this many items
   localparam int WDOG_LIMIT = 300000;   // covers the clearing pass after reset
   localparam int DRAIN_CYC  = 60;

   localparam logic [6:0] OPC_SYSTEM = 7'h73;
   // funct3 codes of the divide group (M extension)
   localparam logic [2:0] F3_DIV  = 3'd4;
   localparam logic [2:0] F3_DIVU = 3'd5;
   localparam logic [2:0] F3_REM  = 3'd6;
   localparam logic [2:0] F3_REMU = 3'd7;

   // one expected result of a transaction
   typedef struct {
      bit [31:0] exec_pc;
      bit [31:0] word;
      bit        dest_wr;
      bit [4:0]  dest_idx;
      bit [31:0] dest_val;
      bit [31:0] next_pc;
      bit [2:0]  status;
   } hart_result_t;

   // -------------------------------------------------------------------------
   // Scoreboard: its own copy of the hart (registers, pc, memory, halt flag).
   // note_transaction() advances it and queues the expected result,
   // check_result() compares a returned result with the oldest one.
   // -------------------------------------------------------------------------
   class hart_scoreboard;
      bit [31:0]    regs [32];
      bit [31:0]    pc_q;
      bit [7:0]     mem [MEM_BYTES];
      bit           halted;
      hart_result_t expected_results [$];
      int           errors;
      int           n_loads;
      int           n_steps;

      function new();
         pc_q   = RESET_PC;
         halted = 1'b0;
      endfunction

      function void set_start(bit [31:0] v);
         pc_q = v;
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      function bit [31:0] sx(bit [31:0] v, int bits);
         bit [31:0] m;
         m = 32'd1 << (bits - 1);
         v &= (m << 1) - 32'd1;
         return (v ^ m) - m;
      endfunction

      function bit mem_rd(bit [31:0] addr, int n, output bit [31:0] val);
         bit [31:0] idx;
         idx = addr - MEM_BASE;
         val = 0;
         if (idx > MEM_BYTES - n) return 1'b0;
         for (int k = 0; k < n; k++) val |= 32'(mem[idx + k]) << (8 * k);
         return 1'b1;
      endfunction

      function bit mem_wr(bit [31:0] addr, int n, bit [31:0] val);
         bit [31:0] idx;
         idx = addr - MEM_BASE;
         if (idx > MEM_BYTES - n) return 1'b0;
         for (int k = 0; k < n; k++) mem[idx + k] = val[8*k +: 8];
         return 1'b1;
      endfunction

      function bit [31:0] div_rem(bit [31:0] a, bit [31:0] b, bit [2:0] f3);
         bit [31:0] ma, mb, q;
         ma = a[31] ? -a : a;
         mb = b[31] ? -b : b;
         case (f3)
            F3_DIV: begin
               if (b == 0) return ALL_ONES;
               if (a == 32'h8000_0000 && b == ALL_ONES) return a;
               q = ma / mb;
               return (a[31] != b[31]) ? -q : q;
            end
            F3_DIVU: return (b == 0) ? ALL_ONES : a / b;
            F3_REM: begin
               if (b == 0) return a;
               if (a == 32'h8000_0000 && b == ALL_ONES) return 0;
               q = ma % mb;
               return a[31] ? -q : q;
            end
            default: return (b == 0) ? a : a % b;
         endcase
      endfunction

      function void note_transaction(bit op, bit [31:0] laddr, bit [31:0] ldata);
         hart_result_t r;
         bit [31:0] pc, ins, npc, wv, a, b, imm, addr, v, off;
         bit [63:0] sa, sb, ua, ub;
         bit [4:0]  rd;
         bit [2:0]  f3, st;
         bit [6:0]  f7;
         bit        wr, taken;
         r   = '{default: 0};
         pc  = pc_q;
         ins = 0;
         wr  = 1'b0;
         wv  = 0;
         rd  = 0;
         st  = ST_OK;
         if (!op) begin
            n_loads++;
            if (!mem_wr(laddr, 4, ldata)) st = ST_RANGE;
         end else begin
            n_steps++;
            r.exec_pc = pc;
            if (halted) begin
               st = ST_HALTED;
            end else if (!mem_rd(pc, 4, ins)) begin
               st = ST_RANGE;
               halted = 1'b1;
            end else if (ins == W_ECALL) begin
               st = ST_ECALL;
               halted = 1'b1;
            end else if (ins == W_EBREAK) begin
               st = ST_EBREAK;
               halted = 1'b1;
            end else if (ins == 0) begin
               st = ST_NULL;
               halted = 1'b1;
            end else begin
               rd  = ins[11:7];
               f3  = ins[14:12];
               f7  = ins[31:25];
               a   = regs[ins[19:15]];
               b   = regs[ins[24:20]];
               imm = sx(ins >> 20, 12);
               npc = pc + 4;
               sa  = {{32{a[31]}}, a};
               sb  = {{32{b[31]}}, b};
               ua  = {32'd0, a};
               ub  = {32'd0, b};
               case (ins[6:0])
                  OPC_OPIMM: begin
                     wr = 1'b1;
                     case (f3)
                        F3_ADD:  wv = a + imm;
                        F3_SLL:  wv = a << imm[4:0];
                        F3_SLT:  wv = ($signed(a) < $signed(imm)) ? 1 : 0;
                        F3_SLTU: wv = (a < imm) ? 1 : 0;
                        F3_XOR:  wv = a ^ imm;
                        F3_SR: begin
                           if (f7 == F7_BASE) wv = a >> imm[4:0];
                           else if (f7 == F7_ALT) wv = $signed(a) >>> imm[4:0];
                           else wr = 1'b0;
                        end
                        F3_OR:   wv = a | imm;
                        default: wv = a & imm;
                     endcase
                  end
                  OPC_OP: begin
                     wr = 1'b1;
                     if (f7 == F7_BASE) begin
                        case (f3)
                           F3_ADD:  wv = a + b;
                           F3_SLL:  wv = a << b[4:0];
                           F3_SLT:  wv = ($signed(a) < $signed(b)) ? 1 : 0;
                           F3_SLTU: wv = (a < b) ? 1 : 0;
                           F3_XOR:  wv = a ^ b;
                           F3_SR:   wv = a >> b[4:0];
                           F3_OR:   wv = a | b;
                           default: wv = a & b;
                        endcase
                     end else if (f7 == F7_ALT && f3 == F3_ADD) begin
                        wv = a - b;
                     end else if (f7 == F7_ALT && f3 == F3_SR) begin
                        wv = $signed(a) >>> b[4:0];
                     end else if (f7 == F7_MULDIV) begin
                        case (f3)
                           F3_MUL:    wv = a * b;
                           F3_MULH:   wv = 32'((sa * sb) >> 32);
                           F3_MULHSU: wv = 32'((sa * ub) >> 32);
                           F3_MULHU:  wv = 32'((ua * ub) >> 32);
                           default:   wv = div_rem(a, b, f3);
                        endcase
                     end else begin
                        wr = 1'b0;
                     end
                  end
                  OPC_LUI: begin
                     wr = 1'b1;
                     wv = {ins[31:12], 12'd0};
                  end
                  OPC_AUIPC: begin
                     wr = 1'b1;
                     wv = pc + {ins[31:12], 12'd0};
                  end
                  OPC_JAL: begin
                     off = {11'd0, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
                     wr  = 1'b1;
                     wv  = pc + 4;
                     npc = pc + sx(off, 21);
                  end
                  OPC_JALR: begin
                     wr  = 1'b1;
                     wv  = pc + 4;
                     npc = (a + imm) & ~32'd1;
                  end
                  OPC_BRANCH: begin
                     off = {19'd0, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
                     case (f3)
                        F3_BEQ:  taken = (a == b);
                        F3_BNE:  taken = (a != b);
                        F3_BLT:  taken = ($signed(a) < $signed(b));
                        F3_BGE:  taken = ($signed(a) >= $signed(b));
                        F3_BLTU: taken = (a < b);
                        F3_BGEU: taken = (a >= b);
                        default: taken = 1'b0;   // funct3 2 and 3 never branch
                     endcase
                     if (taken) npc = pc + sx(off, 13);
                  end
                  OPC_LOAD: begin
                     addr = a + imm;
                     wr   = 1'b1;
                     case (f3)
                        F3_LB: begin
                           if (!mem_rd(addr, 1, v)) st = ST_RANGE;
                           wv = sx(v, 8);
                        end
                        F3_LH: begin
                           if (!mem_rd(addr, 2, v)) st = ST_RANGE;
                           wv = sx(v, 16);
                        end
                        F3_LW: begin
                           if (!mem_rd(addr, 4, v)) st = ST_RANGE;
                           wv = v;
                        end
                        F3_LBU: begin
                           if (!mem_rd(addr, 1, v)) st = ST_RANGE;
                           wv = v;
                        end
                        F3_LHU: begin
                           if (!mem_rd(addr, 2, v)) st = ST_RANGE;
                           wv = v;
                        end
                        default: wr = 1'b0;
                     endcase
                  end
                  OPC_STORE: begin
                     addr = a + sx({20'd0, ins[31:25], ins[11:7]}, 12);
                     if (f3 <= 3'd2 && !mem_wr(addr, 1 << f3, b)) st = ST_RANGE;
                  end
                  default: begin
                     st  = ST_UNKNOWN;
                     npc = 32'd4;
                  end
               endcase
               if (wr && rd != 0) regs[rd] = wv;
               else wr = 1'b0;
               pc_q = npc;
            end
            r.word = ins;
         end
         if (wr) begin
            r.dest_wr  = 1'b1;
            r.dest_idx = rd;
            r.dest_val = wv;
         end
         r.next_pc = pc_q;
         r.status  = st;
         expected_results.push_back(r);
      endfunction

      task report(string what, bit [31:0] got, bit [31:0] want);
         errors++;
         if (errors <= 40)
            $display("[%0t] mismatch %s: got %h expected %h", $realtime, what, got, want);
      endtask

      task check_result(bit [135:0] d, bit [2:0] u);
         hart_result_t e;
         if (expected_results.size() == 0) begin
            report("unexpected result, exec_pc", d[31:0], 0);
            return;
         end
         e = expected_results.pop_front();
         if (d[31:0]    != e.exec_pc)  report("exec_pc", d[31:0], e.exec_pc);
         if (d[63:32]   != e.word)     report("fetched_word", d[63:32], e.word);
         if (d[64]      != e.dest_wr)  report("dest_written", d[64], e.dest_wr);
         if (d[69:65]   != e.dest_idx) report("dest_index", d[69:65], e.dest_idx);
         if (d[101:70]  != e.dest_val) report("dest_value", d[101:70], e.dest_val);
         if (d[133:102] != e.next_pc)  report("next_pc", d[133:102], e.next_pc);
         if (u          != e.status)   report("status", u, e.status);
      endtask
   endclass

   // -------------------------------------------------------------------------
   // DUT hookup
   // -------------------------------------------------------------------------
   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         csr_wen = 1'b0;
   logic [31:0]  csr_wdata = '0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [63:0]  req_tdata = '0;   // [31:0] load_address, [63:32] load_data
   logic         req_tuser = 1'b0; // op
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [135:0] rsp_tdata;        // exec_pc, fetched_word, dest_written,
                                   // dest_index, dest_value, next_pc, pad
   logic [2:0]   rsp_tuser;        // status

   rv32im_instruction_executor_core #(.MEM_BYTES(MEM_BYTES)) DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   hart_scoreboard sb = new();
   bit quiet = 1'b0;      // set for the last stretch: no idling on either side
   int n_cfg = 0;
   int idle_cycles = 0;
   int rsp_stall = 0;

   // Receiver: random low bursts of rsp_tready, steady high once quiet.
   always @(posedge clock) begin
      if (quiet) begin
         rsp_tready <= 1'b1;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 6) == 0) begin
         rsp_stall = $urandom_range(1, 5) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Result monitor plus watchdog on cycles with no transaction at all.
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser);
      if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)) begin
         idle_cycles = 0;
      end else if (!reset) begin
         idle_cycles++;
         if (idle_cycles >= WDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WDOG_LIMIT);
            $display("FAIL");
            $finish;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Instruction encoders
   // -------------------------------------------------------------------------
   function automatic bit [31:0] enc_r(bit [6:0] f7, bit [4:0] rs2, bit [4:0] rs1,
                                       bit [2:0] f3, bit [4:0] rd);
      return {f7, rs2, rs1, f3, rd, OPC_OP};
   endfunction

   function automatic bit [31:0] enc_i(bit [11:0] imm, bit [4:0] rs1, bit [2:0] f3,
                                       bit [4:0] rd, bit [6:0] opc);
      return {imm, rs1, f3, rd, opc};
   endfunction

   function automatic bit [31:0] enc_s(bit [11:0] imm, bit [4:0] rs2, bit [4:0] rs1,
                                       bit [2:0] f3);
      return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_STORE};
   endfunction

   function automatic bit [31:0] enc_b(bit [12:0] o, bit [4:0] rs2, bit [4:0] rs1,
                                       bit [2:0] f3);
      return {o[12], o[10:5], rs2, rs1, f3, o[4:1], o[11], OPC_BRANCH};
   endfunction

   function automatic bit [31:0] enc_j(bit [20:0] o, bit [4:0] rd);
      return {o[20], o[10:1], o[11], o[19:12], rd, OPC_JAL};
   endfunction

   function automatic bit is_known(bit [6:0] opc);
      return opc inside {OPC_OPIMM, OPC_OP, OPC_LUI, OPC_AUIPC, OPC_JAL,
                         OPC_JALR, OPC_BRANCH, OPC_LOAD, OPC_STORE};
   endfunction

   // a register whose value points into memory, if the hart holds one
   function automatic bit [4:0] pick_base();
      int s;
      s = $urandom_range(0, 31);
      for (int i = 0; i < 32; i++)
         if (sb.regs[(s + i) % 32] - MEM_BASE < MEM_BYTES) return 5'((s + i) % 32);
      return 5'($urandom);
   endfunction

   function automatic bit [6:0] pick_f7();
      case ($urandom_range(0, 3))
         0: return F7_BASE;
         1: return F7_ALT;
         2: return F7_MULDIV;
         default: return 7'($urandom);
      endcase
   endfunction

   // random non-halting instruction word
   function automatic bit [31:0] gen_insn();
      bit [31:0] w;
      bit [6:0]  opc;
      int        k;
      do begin
         k = $urandom_range(0, 99);
         w = $urandom;
         if (k < 18) begin
            w[6:0] = OPC_OPIMM;
            if ($urandom_range(0, 2) != 0) w[31:25] = $urandom_range(0, 1) ? F7_ALT : F7_BASE;
         end else if (k < 40) begin
            w = enc_r(pick_f7(), 5'($urandom), 5'($urandom), 3'($urandom), 5'($urandom));
         end else if (k < 48) begin
            w[6:0] = OPC_LUI;
            if ($urandom_range(0, 1)) w[31:12] = 20'h80000 | 20'($urandom_range(0, 15));
         end else if (k < 52) begin
            w[6:0] = OPC_AUIPC;
         end else if (k < 58) begin
            w = enc_j($urandom_range(0, 7) ? 21'($signed($urandom_range(0, 1023)) - 512)
                                          : 21'($urandom), 5'($urandom));
         end else if (k < 61) begin
            w[6:0] = OPC_JALR;
            if ($urandom_range(0, 1)) w[19:15] = pick_base();
         end else if (k < 72) begin
            w = enc_b(13'($urandom), 5'($urandom), 5'($urandom), 3'($urandom));
         end else if (k < 83) begin
            w = enc_i(12'($urandom_range(0, 1) ? $urandom_range(0, 255) : $urandom),
                      pick_base(), 3'($urandom), 5'($urandom), OPC_LOAD);
         end else if (k < 94) begin
            w = enc_s(12'($urandom_range(0, 1) ? $urandom_range(0, 255) : $urandom),
                      5'($urandom), pick_base(), 3'($urandom));
         end else if (k < 97) begin
            // unknown opcode, SYSTEM words other than the halting pair included
            if ($urandom_range(0, 2) == 0) opc = OPC_SYSTEM;
            else do opc = 7'($urandom); while (is_known(opc));
            w[6:0] = opc;
         end
      end while (w == 0 || w == W_ECALL || w == W_EBREAK);
      return w;
   endfunction

   // -------------------------------------------------------------------------
   // Driver tasks
   // -------------------------------------------------------------------------
   task send(bit op, bit [31:0] addr, bit [31:0] data);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {data, addr};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_transaction(op, addr, data);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   task wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task cfg_write(bit [31:0] v);
      wait_idle();
      csr_wen   <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_wen <= 1'b0;
      sb.set_start(v);
      n_cfg++;
   endtask

   // Put a word at the predicted pc and step it; re-seat pc through the
   // start_pc register whenever it has wandered off the memory.
   task run_insn(bit [31:0] w);
      bit [31:0] npc;
      if (sb.pc_q - MEM_BASE > MEM_BYTES - 4) begin
         npc = $urandom_range(0, 7) ? {$urandom_range(0, MEM_BYTES / 4 - 1), 2'b00}
                                    : $urandom_range(0, MEM_BYTES - 4);
         cfg_write(MEM_BASE + npc);
      end
      send(1'b0, sb.pc_q, w);
      send(1'b1, $urandom, $urandom);
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      bit [31:0] dir_prog [$];
      int        n, halt_kind;
      bit [31:0] a;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: corner values of the M extension, shifts, memory widths,
      // misaligned access, x0, branches, jumps and an unknown opcode.
      cfg_write(RESET_PC);
      dir_prog = '{
         {20'h80000, 5'd1, OPC_LUI},                       // x1 = 0x80000000
         enc_i(12'hFFF, 5'd0, F3_ADD, 5'd2, OPC_OPIMM),     // x2 = -1
         enc_i(12'h7FF, 5'd0, F3_ADD, 5'd5, OPC_OPIMM),     // x5 = 2047
         enc_r(F7_MULDIV, 5'd2, 5'd1, F3_DIV, 5'd4),        // overflow divide
         enc_r(F7_MULDIV, 5'd2, 5'd1, F3_REM, 5'd4),
         enc_r(F7_MULDIV, 5'd3, 5'd5, F3_DIV, 5'd4),        // divide by zero
         enc_r(F7_MULDIV, 5'd3, 5'd5, F3_DIVU, 5'd4),
         enc_r(F7_MULDIV, 5'd3, 5'd5, F3_REM, 5'd4),
         enc_r(F7_MULDIV, 5'd3, 5'd1, F3_REMU, 5'd4),
         enc_r(F7_MULDIV, 5'd2, 5'd1, F3_MULH, 5'd6),
         enc_r(F7_MULDIV, 5'd2, 5'd2, F3_MULHSU, 5'd6),
         enc_r(F7_MULDIV, 5'd2, 5'd2, F3_MULHU, 5'd6),
         enc_r(F7_MULDIV, 5'd2, 5'd2, F3_MUL, 5'd6),
         enc_i({F7_ALT, 5'd31}, 5'd1, F3_SR, 5'd7, OPC_OPIMM),
         enc_r(F7_BASE, 5'd5, 5'd1, F3_SLT, 5'd7),
         enc_r(F7_ALT, 5'd2, 5'd0, F3_ADD, 5'd7),
         enc_s(12'h100, 5'd2, 5'd1, F3_LW),                 // sw x2, 0x100(x1)
         enc_i(12'h100, 5'd1, F3_LB, 5'd8, OPC_LOAD),
         enc_i(12'h101, 5'd1, F3_LHU, 5'd8, OPC_LOAD),      // misaligned
         enc_i(12'h000, 5'd2, F3_LW, 5'd9, OPC_LOAD),       // out of range
         enc_i(12'h005, 5'd0, F3_ADD, 5'd0, OPC_OPIMM),     // x0 stays zero
         enc_b(13'h008, 5'd5, 5'd1, F3_BLT),
         enc_j(21'h10, 5'd10),
         enc_i(12'h001, 5'd1, F3_ADD, 5'd11, OPC_JALR),     // bit 0 cleared
         32'h0000_007F                                      // unknown opcode
      };
      foreach (dir_prog[i]) run_insn(dir_prog[i]);
      send(1'b0, 32'hFFFF_FFFC, $urandom);                 // load item off memory
      cfg_write(MEM_BASE + MEM_BYTES - 4);                 // top word of memory
      run_insn(enc_r(F7_BASE, 5'd2, 5'd1, F3_XOR, 5'd12));
      cfg_write(32'h0000_0000);

      // Random part: mostly placed-and-stepped instructions, some stray
      // load items, and now and then a full drain before continuing.
      n = 0;
      while (n < RAND_ITEMS) begin
         quiet = (n >= QUIET_FROM);
         if ($urandom_range(0, 12) == 0) begin
            a = $urandom_range(0, 1) ? MEM_BASE + $urandom_range(0, MEM_BYTES - 1)
                                     : $urandom;
            send(1'b0, a, $urandom);
            n++;
         end else begin
            run_insn(gen_insn());
            n += 2;
         end
         if (!quiet && $urandom_range(0, 150) == 0) wait_idle();
      end

      // Halting is sticky until reset, so exactly one halt kind closes the run.
      halt_kind = $urandom_range(0, 3);
      case (halt_kind)
         0: run_insn(W_ECALL);
         1: run_insn(W_EBREAK);
         2: run_insn(32'h0000_0000);
         default: begin
            cfg_write(ALL_ONES);
            send(1'b1, $urandom, $urandom);                // fetch off memory
         end
      endcase
      send(1'b1, $urandom, $urandom);                     // step while halted
      send(1'b0, MEM_BASE + 32'h40, $urandom);            // load item still taken
      send(1'b1, $urandom, $urandom);

      wait_idle();
      repeat (DRAIN_CYC) @(posedge clock);

      $display("covered %0d load and %0d step transactions, %0d start_pc writes,",
               sb.n_loads, sb.n_steps, n_cfg);
      $display("directed M-extension corners and halt kind %0d", halt_kind);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches, %0d results missing", sb.errors, sb.pending());
         $display("FAIL");
      end
      $finish;
   end

endmodule
